// ----- hdl/dcet_pkg.sv -----
// ----------------------------------------------------------------------------
// dcet_pkg
// Shared widths, latencies, codes and types of the disc collision event
// time core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcet_pkg;

    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_LAT    = DIV_DEN_W + 1;
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int SQRT_LAT   = SQRT_OUT_W + 1;

    localparam logic [1:0] ACT_PAIR  = 2'd0;
    localparam logic [1:0] ACT_VWALL = 2'd1;
    localparam logic [1:0] ACT_HWALL = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_VWALL = 2'd1;
    localparam logic [1:0] EV_HWALL = 2'd2;
    localparam logic [1:0] EV_BALLS = 2'd3;

    localparam logic [20:0] RPW_RESET = 21'd65536;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic                 neg;
        logic                 has;
    } t_wall;

endpackage

// ----- hdl/disc_collision_event_time_core.sv -----
// ----------------------------------------------------------------------------
// disc_collision_event_time_core
// Path: a request passes s1 to s5, the root and divider pipelines, f1, f2 and the output register.
// Throughput: one request per cycle while the skid entry is empty; the root and divider pipelines set depth.
// Reset clears all valid bits and sets radius_per_weight to 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_collision_event_time_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [20:0]        i_cfg_radius_per_weight,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [30:0]        i_now_time,
    input  logic signed [31:0] i_a_pos_x,
    input  logic signed [31:0] i_a_pos_y,
    input  logic signed [31:0] i_a_vel_x,
    input  logic signed [31:0] i_a_vel_y,
    input  logic [15:0]        i_a_weight,
    input  logic signed [31:0] i_b_pos_x,
    input  logic signed [31:0] i_b_pos_y,
    input  logic signed [31:0] i_b_vel_x,
    input  logic signed [31:0] i_b_vel_y,
    input  logic [15:0]        i_b_weight,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_event_kind,
    output logic [30:0]        o_event_time
);

    localparam int SL = dcet_pkg::SQRT_LAT;
    localparam int DL = dcet_pkg::DIV_LAT;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        logic signed [31:0] ax, ay, avx, avy;
        logic [15:0]        aw;
        logic signed [31:0] bx, by, bvx, bvy;
        logic [15:0]        bw;
    } t_s1;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        logic signed [31:0] ax, ay, avx, avy, bx, by, bvx, bvy;
        logic [20:0]        ra, rb;
        logic signed [31:0] dx, dy, dvx, dvy;
    } t_s2;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        logic signed [33:0] g_ax, g_ay, g_bx, g_by;
        logic [3:0]         vneg;
        logic [3:0]         vnz;
        logic [31:0]        d_ax, d_ay, d_bx, d_by;
        logic signed [63:0] pb_x, pb_y, pa_x, pa_y, pc_x, pc_y;
        logic [43:0]        pr;
    } t_s3;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        dcet_pkg::t_wall    w_ax, w_ay, w_bx, w_by;
        logic signed [31:0] bq, aq, cq;
    } t_s4;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        dcet_pkg::t_wall    w_ax, w_ay, w_bx, w_by;
        logic signed [31:0] bq, aq;
        logic               noc;
        logic signed [63:0] bb, ac;
    } t_s5;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        logic signed [31:0] bq, aq;
        logic               pair_ok;
        dcet_pkg::t_wall    w_ax, w_ay, w_bx, w_by;
    } t_d1;

    typedef struct packed {
        logic [1:0]  action;
        logic [30:0] now;
        logic        pair_ok;
        logic [3:0]  neg;
        logic [3:0]  has;
    } t_d2;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        logic               pair_ok;
        logic [3:0]         has;
        logic signed [31:0] t_ax, t_ay, t_bx, t_by, tp;
    } t_f1;

    typedef struct packed {
        logic [1:0]         action;
        logic [30:0]        now;
        logic signed [31:0] dt;
        logic               dt_ok;
        logic signed [31:0] bnd_a, bnd_b;
        logic               has_a, has_b;
    } t_f2;

    function automatic logic signed [31:0] f_sat(input logic signed [49:0] v);
        logic signed [31:0] res;
        if (v > 50'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [33:0] f_gap(input logic signed [31:0] p,
                                                input logic signed [31:0] v,
                                                input logic [20:0] r);
        logic signed [33:0] ps;
        logic signed [33:0] rs;
        ps = 34'(p);
        rs = $signed({13'b0, r});
        return v[31] ? (rs - ps) : (34'sd65536 - rs - ps);
    endfunction

    function automatic logic signed [49:0] f_fl(input logic signed [63:0] x);
        return 50'(x >>> 16);
    endfunction

    function automatic logic signed [31:0] f_quo(input logic [31:0] q,
                                                input logic ovf, input logic neg);
        logic signed [31:0] res;
        if (!neg) begin
            res = (ovf || q[31]) ? 32'sh7fffffff : $signed(q);
        end else if (ovf || q > 32'h80000000) begin
            res = 32'sh80000000;
        end else begin
            res = $signed(~q + 32'd1);
        end
        return res;
    endfunction

    function automatic dcet_pkg::t_wall f_wall(input logic signed [33:0] g,
                                               input logic vneg, input logic vnz,
                                               input logic [31:0] den);
        dcet_pkg::t_wall w;
        logic signed [33:0] mag;
        mag   = g[33] ? -g : g;
        w.num = {mag[31:0], 16'b0};
        w.den = den;
        w.neg = g[33] ^ vneg;
        w.has = vnz;
        return w;
    endfunction

    function automatic logic signed [31:0] f_bound(input logic signed [31:0] tx,
                                                  input logic hx,
                                                  input logic signed [31:0] ty,
                                                  input logic hy);
        logic signed [31:0] res;
        if (hx && hy) begin
            res = (tx < ty) ? tx : ty;
        end else if (hx) begin
            res = tx;
        end else begin
            res = ty;
        end
        return res;
    endfunction

    function automatic logic f_within(input logic signed [31:0] dt, input logic has,
                                      input logic signed [31:0] bnd);
        return !dt[31] && (!has || dt <= bnd);
    endfunction

    logic        r_rpw_en;
    logic [20:0] r_rpw;
    logic        en;

    logic    r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    t_s1     r_s1;
    t_s2     r_s2, n_s2;
    t_s3     r_s3, n_s3;
    t_s4     r_s4, n_s4;
    t_s5     r_s5, n_s5;

    logic [SL-1:0] r_d1_vld;
    t_d1           r_d1 [SL];
    t_d1           n_d1;
    logic [DL-1:0] r_d2_vld;
    t_d2           r_d2 [DL];
    t_d2           n_d2;

    logic r_f1_vld, r_f2_vld;
    t_f1  r_f1, n_f1;
    t_f2  r_f2, n_f2;

    logic [36:0]        n_pa, n_pb;
    logic [21:0]        n_rsum;
    logic signed [64:0] n_disc;
    logic [31:0]        n_root;
    logic signed [32:0] n_pnum;
    t_d1                d1_o;
    t_d2                d2_o;

    logic [31:0] q_p, q_ax, q_ay, q_bx, q_by;
    logic        v_p, v_ax, v_ay, v_bx, v_by;

    logic [3:0]  n_hx;
    logic        n_wa, n_wb, n_hit;
    logic [1:0]  n_kind;
    logic [31:0] n_sum;
    logic [30:0] n_time;

    logic        r_out_valid, r_skid_valid;
    logic [1:0]  r_out_kind, r_skid_kind;
    logic [30:0] r_out_time, r_skid_time;

    assign r_rpw_en    = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign en          = !r_skid_valid;
    assign o_in_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpw <= dcet_pkg::RPW_RESET;
        end else if (r_rpw_en) begin
            r_rpw <= i_cfg_radius_per_weight;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_d1_vld <= '0;
            r_d2_vld <= '0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_d1_vld <= {r_d1_vld[SL-2:0], r_s5_vld};
            r_d2_vld <= {r_d2_vld[DL-2:0], r_d1_vld[SL-1]};
            r_f1_vld <= r_d2_vld[DL-1];
            r_f2_vld <= r_f1_vld;
        end
    end

    always_comb begin
        n_pa = {21'b0, r_s1.aw} * {16'b0, r_rpw};
        n_pb = {21'b0, r_s1.bw} * {16'b0, r_rpw};
        n_s2.action = r_s1.action;
        n_s2.now    = r_s1.now;
        n_s2.ax     = r_s1.ax;
        n_s2.ay     = r_s1.ay;
        n_s2.avx    = r_s1.avx;
        n_s2.avy    = r_s1.avy;
        n_s2.bx     = r_s1.bx;
        n_s2.by     = r_s1.by;
        n_s2.bvx    = r_s1.bvx;
        n_s2.bvy    = r_s1.bvy;
        n_s2.ra     = n_pa[36:16];
        n_s2.rb     = n_pb[36:16];
        n_s2.dx     = f_sat(50'(r_s1.bx) - 50'(r_s1.ax));
        n_s2.dy     = f_sat(50'(r_s1.by) - 50'(r_s1.ay));
        n_s2.dvx    = f_sat(50'(r_s1.bvx) - 50'(r_s1.avx));
        n_s2.dvy    = f_sat(50'(r_s1.bvy) - 50'(r_s1.avy));
    end

    always_comb begin
        n_rsum      = {1'b0, r_s2.ra} + {1'b0, r_s2.rb};
        n_s3.action = r_s2.action;
        n_s3.now    = r_s2.now;
        n_s3.g_ax   = f_gap(r_s2.ax, r_s2.avx, r_s2.ra);
        n_s3.g_ay   = f_gap(r_s2.ay, r_s2.avy, r_s2.ra);
        n_s3.g_bx   = f_gap(r_s2.bx, r_s2.bvx, r_s2.rb);
        n_s3.g_by   = f_gap(r_s2.by, r_s2.bvy, r_s2.rb);
        n_s3.vneg   = {r_s2.bvy[31], r_s2.bvx[31], r_s2.avy[31], r_s2.avx[31]};
        n_s3.vnz    = {r_s2.bvy != 0, r_s2.bvx != 0, r_s2.avy != 0, r_s2.avx != 0};
        n_s3.d_ax   = r_s2.avx[31] ? 32'(-r_s2.avx) : 32'(r_s2.avx);
        n_s3.d_ay   = r_s2.avy[31] ? 32'(-r_s2.avy) : 32'(r_s2.avy);
        n_s3.d_bx   = r_s2.bvx[31] ? 32'(-r_s2.bvx) : 32'(r_s2.bvx);
        n_s3.d_by   = r_s2.bvy[31] ? 32'(-r_s2.bvy) : 32'(r_s2.bvy);
        n_s3.pb_x   = 64'(r_s2.dvx) * 64'(r_s2.dx);
        n_s3.pb_y   = 64'(r_s2.dvy) * 64'(r_s2.dy);
        n_s3.pa_x   = 64'(r_s2.dvx) * 64'(r_s2.dvx);
        n_s3.pa_y   = 64'(r_s2.dvy) * 64'(r_s2.dvy);
        n_s3.pc_x   = 64'(r_s2.dx) * 64'(r_s2.dx);
        n_s3.pc_y   = 64'(r_s2.dy) * 64'(r_s2.dy);
        n_s3.pr     = {22'b0, n_rsum} * {22'b0, n_rsum};
    end

    always_comb begin
        n_s4.action = r_s3.action;
        n_s4.now    = r_s3.now;
        n_s4.w_ax   = f_wall(r_s3.g_ax, r_s3.vneg[0], r_s3.vnz[0], r_s3.d_ax);
        n_s4.w_ay   = f_wall(r_s3.g_ay, r_s3.vneg[1], r_s3.vnz[1], r_s3.d_ay);
        n_s4.w_bx   = f_wall(r_s3.g_bx, r_s3.vneg[2], r_s3.vnz[2], r_s3.d_bx);
        n_s4.w_by   = f_wall(r_s3.g_by, r_s3.vneg[3], r_s3.vnz[3], r_s3.d_by);
        n_s4.bq     = f_sat(f_fl(r_s3.pb_x) + f_fl(r_s3.pb_y));
        n_s4.aq     = f_sat(f_fl(r_s3.pa_x) + f_fl(r_s3.pa_y));
        n_s4.cq     = f_sat(f_fl(r_s3.pc_x) + f_fl(r_s3.pc_y)
                            - $signed({22'b0, r_s3.pr[43:16]}));
    end

    always_comb begin
        n_s5.action = r_s4.action;
        n_s5.now    = r_s4.now;
        n_s5.w_ax   = r_s4.w_ax;
        n_s5.w_ay   = r_s4.w_ay;
        n_s5.w_bx   = r_s4.w_bx;
        n_s5.w_by   = r_s4.w_by;
        n_s5.bq     = r_s4.bq;
        n_s5.aq     = r_s4.aq;
        n_s5.noc    = (r_s4.cq < 0) || (r_s4.bq > 0) || (r_s4.aq == 0);
        n_s5.bb     = 64'(r_s4.bq) * 64'(r_s4.bq);
        n_s5.ac     = 64'(r_s4.aq) * 64'(r_s4.cq);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= '{i_action, i_now_time, i_a_pos_x, i_a_pos_y, i_a_vel_x,
                      i_a_vel_y, i_a_weight, i_b_pos_x, i_b_pos_y, i_b_vel_x,
                      i_b_vel_y, i_b_weight};
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
        end
    end

    always_comb begin
        n_disc         = 65'(r_s5.bb) - 65'(r_s5.ac);
        n_d1.action    = r_s5.action;
        n_d1.now       = r_s5.now;
        n_d1.bq        = r_s5.bq;
        n_d1.aq        = r_s5.aq;
        n_d1.pair_ok   = !r_s5.noc && !n_disc[64];
        n_d1.w_ax      = r_s5.w_ax;
        n_d1.w_ay      = r_s5.w_ay;
        n_d1.w_bx      = r_s5.w_bx;
        n_d1.w_by      = r_s5.w_by;
    end

    dcet_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (n_disc[63:0]),
        .o_root (n_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1[0] <= n_d1;
            for (int k = 1; k < SL; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    always_comb begin
        d1_o         = r_d1[SL-1];
        n_pnum       = -33'(d1_o.bq) - $signed({1'b0, n_root});
        n_d2.action  = d1_o.action;
        n_d2.now     = d1_o.now;
        n_d2.pair_ok = d1_o.pair_ok;
        n_d2.neg     = {d1_o.w_by.neg, d1_o.w_bx.neg, d1_o.w_ay.neg, d1_o.w_ax.neg};
        n_d2.has     = {d1_o.w_by.has, d1_o.w_bx.has, d1_o.w_ay.has, d1_o.w_ax.has};
    end

    dcet_div u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({n_pnum[31:0], 16'b0}),
        .i_den (d1_o.aq),
        .o_quo (q_p),
        .o_ovf (v_p)
    );

    dcet_div u_div_ax (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (d1_o.w_ax.num),
        .i_den (d1_o.w_ax.den),
        .o_quo (q_ax),
        .o_ovf (v_ax)
    );

    dcet_div u_div_ay (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (d1_o.w_ay.num),
        .i_den (d1_o.w_ay.den),
        .o_quo (q_ay),
        .o_ovf (v_ay)
    );

    dcet_div u_div_bx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (d1_o.w_bx.num),
        .i_den (d1_o.w_bx.den),
        .o_quo (q_bx),
        .o_ovf (v_bx)
    );

    dcet_div u_div_by (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (d1_o.w_by.num),
        .i_den (d1_o.w_by.den),
        .o_quo (q_by),
        .o_ovf (v_by)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= n_d2;
            for (int k = 1; k < DL; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    always_comb begin
        d2_o         = r_d2[DL-1];
        n_f1.action  = d2_o.action;
        n_f1.now     = d2_o.now;
        n_f1.pair_ok = d2_o.pair_ok;
        n_f1.has     = d2_o.has;
        n_f1.t_ax    = f_quo(q_ax, v_ax, d2_o.neg[0]);
        n_f1.t_ay    = f_quo(q_ay, v_ay, d2_o.neg[1]);
        n_f1.t_bx    = f_quo(q_bx, v_bx, d2_o.neg[2]);
        n_f1.t_by    = f_quo(q_by, v_by, d2_o.neg[3]);
        n_f1.tp      = f_quo(q_p, v_p, 1'b0);
    end

    always_comb begin
        n_hx = {r_f1.has[3] && !r_f1.t_by[31], r_f1.has[2] && !r_f1.t_bx[31],
                r_f1.has[1] && !r_f1.t_ay[31], r_f1.has[0] && !r_f1.t_ax[31]};
        n_f2.action = r_f1.action;
        n_f2.now    = r_f1.now;
        n_f2.bnd_a  = f_bound(r_f1.t_ax, n_hx[0], r_f1.t_ay, n_hx[1]);
        n_f2.bnd_b  = f_bound(r_f1.t_bx, n_hx[2], r_f1.t_by, n_hx[3]);
        n_f2.has_a  = n_hx[0] || n_hx[1];
        n_f2.has_b  = n_hx[2] || n_hx[3];
        case (r_f1.action)
            dcet_pkg::ACT_PAIR: begin
                n_f2.dt    = r_f1.tp;
                n_f2.dt_ok = r_f1.pair_ok;
            end
            dcet_pkg::ACT_VWALL: begin
                n_f2.dt    = r_f1.t_ax;
                n_f2.dt_ok = r_f1.has[0];
            end
            dcet_pkg::ACT_HWALL: begin
                n_f2.dt    = r_f1.t_ay;
                n_f2.dt_ok = r_f1.has[1];
            end
            default: begin
                n_f2.dt    = '0;
                n_f2.dt_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

    always_comb begin
        n_wa  = f_within(r_f2.dt, r_f2.has_a, r_f2.bnd_a);
        n_wb  = f_within(r_f2.dt, r_f2.has_b, r_f2.bnd_b);
        n_hit = r_f2.dt_ok && n_wa && ((r_f2.action != dcet_pkg::ACT_PAIR) || n_wb);
        case (r_f2.action)
            dcet_pkg::ACT_PAIR:  n_kind = dcet_pkg::EV_BALLS;
            dcet_pkg::ACT_VWALL: n_kind = dcet_pkg::EV_VWALL;
            dcet_pkg::ACT_HWALL: n_kind = dcet_pkg::EV_HWALL;
            default:             n_kind = dcet_pkg::EV_NONE;
        endcase
        if (!n_hit) begin
            n_kind = dcet_pkg::EV_NONE;
        end
        n_sum  = {1'b0, r_f2.now} + {1'b0, r_f2.dt[30:0]};
        n_time = !n_hit ? r_f2.now : (n_sum[31] ? '1 : n_sum[30:0]);
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_f2_vld;
            end
        end else if (r_f2_vld && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_kind <= r_skid_kind;
                r_out_time <= r_skid_time;
            end else begin
                r_out_kind <= n_kind;
                r_out_time <= n_time;
            end
        end else if (en) begin
            r_skid_kind <= n_kind;
            r_skid_time <= n_time;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_event_time = r_out_time;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry holds a result while the output register is empty.");

    a_stalled_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_f2_vld && en) |=> r_skid_valid)
        else $error("A finished result was dropped while the output was stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_skid_valid))
        else $error("Output buffer is not empty after reset.");

endmodule

// ----- hdl/dcet_div.sv -----
// ----------------------------------------------------------------------------
// dcet_div
// Pipelined restoring divider: one quotient bit per stage, with a flag for
// quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcet_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [dcet_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [dcet_pkg::DIV_DEN_W-1:0] i_den,
    output logic [dcet_pkg::DIV_DEN_W-1:0] o_quo,
    output logic                           o_ovf
);

    localparam int NW = dcet_pkg::DIV_NUM_W;
    localparam int DW = dcet_pkg::DIV_DEN_W;
    localparam int HW = NW - DW;

    logic [DW-1:0] r_rem [DW+1];
    logic [DW-1:0] r_low [DW+1];
    logic [DW-1:0] r_den [DW+1];
    logic [DW-1:0] r_quo [DW+1];
    logic          r_ovf [DW+1];

    logic [DW:0]   n_trial [DW];
    logic [DW:0]   n_diff  [DW];
    logic          n_ge    [DW];
    logic [DW-1:0] n_head;

    always_comb begin
        n_head = {{(DW-HW){1'b0}}, i_num[NW-1:DW]};
        for (int k = 0; k < DW; k++) begin
            n_trial[k] = {r_rem[k], r_low[k][DW-1]};
            n_ge[k]    = n_trial[k] >= {1'b0, r_den[k]};
            n_diff[k]  = n_trial[k] - {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_head;
            r_low[0] <= i_num[DW-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= n_head >= i_den;
            for (int k = 0; k < DW; k++) begin
                r_rem[k+1] <= n_ge[k] ? n_diff[k][DW-1:0] : n_trial[k][DW-1:0];
                r_low[k+1] <= {r_low[k][DW-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= {r_quo[k][DW-2:0], n_ge[k]};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_quo[DW];
    assign o_ovf = r_ovf[DW];

endmodule

// ----- hdl/dcet_sqrt.sv -----
// ----------------------------------------------------------------------------
// dcet_sqrt
// Pipelined integer square root: one root bit per stage, digit by digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcet_sqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [dcet_pkg::SQRT_IN_W-1:0]  i_val,
    output logic [dcet_pkg::SQRT_OUT_W-1:0] o_root
);

    localparam int IW = dcet_pkg::SQRT_IN_W;
    localparam int OW = dcet_pkg::SQRT_OUT_W;

    logic [OW+1:0] r_rem  [OW+1];
    logic [OW-1:0] r_root [OW+1];
    logic [IW-1:0] r_low  [OW+1];

    logic [OW+3:0] n_trial [OW];
    logic [OW+3:0] n_test  [OW];
    logic [OW+3:0] n_diff  [OW];
    logic          n_ge    [OW];

    always_comb begin
        for (int k = 0; k < OW; k++) begin
            n_trial[k] = {r_rem[k], r_low[k][IW-1:IW-2]};
            n_test[k]  = {2'b00, r_root[k], 2'b01};
            n_ge[k]    = n_trial[k] >= n_test[k];
            n_diff[k]  = n_trial[k] - n_test[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_low[0]  <= i_val;
            for (int k = 0; k < OW; k++) begin
                r_rem[k+1]  <= n_ge[k] ? n_diff[k][OW+1:0] : n_trial[k][OW+1:0];
                r_root[k+1] <= {r_root[k][OW-2:0], n_ge[k]};
                r_low[k+1]  <= {r_low[k][IW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[OW];

endmodule
